[hdl/rrbs_pkg.sv]
`timescale 1ns / 1ps

package rrbs_pkg;

   localparam int NUM_SLOTS = 6;

   typedef enum logic [2:0] {
      SLOT_SPECIAL,
      SLOT_MID,
      SLOT_S0_TOP,
      SLOT_S0_BOT,
      SLOT_S1_TOP,
      SLOT_S1_BOT
   } slot_type;

   typedef logic [NUM_SLOTS-1:0] slot_mask_type;

   typedef struct packed {
      logic ready;
      logic active;
   } emit_status_type;

endpackage

[hdl/rrbs_sqrt_cell.sv]
`timescale 1ns / 1ps

module rrbs_sqrt_cell #(
   parameter int RB  = 14,
   parameter int IDX = 0
) (
   input  logic              clock,
   input  logic              advance,
   input  logic [2*RB-1:0]   prev_rad,
   input  logic [RB+1:0]     prev_rem,
   input  logic [RB-1:0]     prev_root,
   output logic [2*RB-1:0]   rad_out,
   output logic [RB+1:0]     rem_out,
   output logic [RB-1:0]     root_out
);
   import rrbs_pkg::*;

   logic [RB+3:0]   cur;
   logic [RB+3:0]   trial;
   logic            fits;
   logic [RB+3:0]   diff;
   logic [RB+1:0]   rem_in;
   logic [RB-1:0]   root_in;
   logic [2*RB-1:0] rad_ff;
   logic [RB+1:0]   rem_ff;
   logic [RB-1:0]   root_ff;

   // one root bit per cell, two radicand bits in
   always_comb begin
      cur     = {prev_rem, prev_rad[2*IDX +: 2]};
      trial   = {2'b00, prev_root, 2'b01};
      fits    = (cur >= trial);
      diff    = cur - trial;
      rem_in  = fits ? diff[RB+1:0] : cur[RB+1:0];
      root_in = {prev_root[RB-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rad_ff  <= prev_rad;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign rad_out  = rad_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;

endmodule

[hdl/rrbs_band_emitter.sv]
`timescale 1ns / 1ps

module rrbs_band_emitter #(
   parameter int CB = 15
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  logic [CB-1:0]             load_w,
   input  logic [CB-1:0]             load_h,
   input  logic [CB-2:0]             load_r,
   input  logic                      load_empty,
   input  logic                      load_steps2,
   input  logic [CB-2:0]             load_inset,
   output rrbs_pkg::emit_status_type status,
   output logic                      rsp_valid,
   output logic [CB-2:0]             rsp_band_x,
   output logic [CB-1:0]             rsp_band_y,
   output logic [CB-1:0]             rsp_band_w,
   output logic [CB-1:0]             rsp_band_h,
   output logic                      rsp_band_valid,
   output logic                      rsp_last_band
);
   import rrbs_pkg::*;

   localparam int RB = CB - 1;

   logic [CB-1:0]  two_r;
   logic [CB-1:0]  two_i;
   logic [RB-1:0]  y1_in;
   logic           m_mid;
   logic           m_s0;
   logic           m_s1;
   slot_mask_type  load_mask;
   logic           whole_in;

   slot_mask_type  mask_ff;
   logic [CB-1:0]  w_ff;
   logic [CB-1:0]  h_ff;
   logic [RB-1:0]  r_ff;
   logic [RB-1:0]  y1_ff;
   logic [RB-1:0]  inset_ff;
   logic           whole_ff;

   slot_mask_type  sel;
   slot_mask_type  rest;
   slot_type       slot;
   logic [RB-1:0]  half_r;
   logic [RB-1:0]  x_in;
   logic [CB-1:0]  y_in;
   logic [CB-1:0]  bw_in;
   logic [CB-1:0]  bh_in;
   logic           bv_in;

   logic           rsp_valid_ff;
   logic [RB-1:0]  rsp_x_ff;
   logic [CB-1:0]  rsp_y_ff;
   logic [CB-1:0]  rsp_w_ff;
   logic [CB-1:0]  rsp_h_ff;
   logic           rsp_bv_ff;
   logic           rsp_last_ff;

   // band plan for a new rectangle
   always_comb begin
      two_r    = {load_r, 1'b0};
      two_i    = {load_inset, 1'b0};
      y1_in    = load_steps2 ? {1'b0, load_r[RB-1:1]} : load_r;
      m_mid    = (load_h > two_r);
      m_s0     = (y1_in != '0) && (load_w > two_r);
      m_s1     = load_steps2 && (load_w > two_i);
      whole_in = 1'b0;
      load_mask = '0;
      if (load_empty) begin
         load_mask[SLOT_SPECIAL] = 1'b1;
      end else if (load_r == '0) begin
         load_mask[SLOT_SPECIAL] = 1'b1;
         whole_in = 1'b1;
      end else if (!m_mid && !m_s0 && !m_s1) begin
         load_mask[SLOT_SPECIAL] = 1'b1;
      end else begin
         load_mask[SLOT_MID]    = m_mid;
         load_mask[SLOT_S0_TOP] = m_s0;
         load_mask[SLOT_S0_BOT] = m_s0;
         load_mask[SLOT_S1_TOP] = m_s1;
         load_mask[SLOT_S1_BOT] = m_s1;
      end
   end

   // lowest pending slot is picked and its band registered for output
   always_comb begin
      sel    = mask_ff & (~mask_ff + 1'b1);
      rest   = mask_ff & ~sel;
      slot   = SLOT_SPECIAL;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (sel[i]) slot = slot_type'(3'(i));
      end
      half_r = {1'b0, r_ff[RB-1:1]};
      x_in   = '0;
      y_in   = '0;
      bw_in  = '0;
      bh_in  = '0;
      bv_in  = 1'b1;
      unique case (slot)
         SLOT_SPECIAL: begin
            bw_in = whole_ff ? w_ff : '0;
            bh_in = whole_ff ? h_ff : '0;
            bv_in = whole_ff;
         end
         SLOT_MID: begin
            y_in  = {1'b0, r_ff};
            bw_in = w_ff;
            bh_in = h_ff - {r_ff, 1'b0};
         end
         SLOT_S0_TOP: begin
            x_in  = r_ff;
            bw_in = w_ff - {r_ff, 1'b0};
            bh_in = {1'b0, y1_ff};
         end
         SLOT_S0_BOT: begin
            x_in  = r_ff;
            y_in  = h_ff - {1'b0, y1_ff};
            bw_in = w_ff - {r_ff, 1'b0};
            bh_in = {1'b0, y1_ff};
         end
         SLOT_S1_TOP: begin
            x_in  = inset_ff;
            y_in  = {1'b0, half_r};
            bw_in = w_ff - {inset_ff, 1'b0};
            bh_in = {1'b0, r_ff - half_r};
         end
         SLOT_S1_BOT: begin
            x_in  = inset_ff;
            y_in  = h_ff - {1'b0, r_ff};
            bw_in = w_ff - {inset_ff, 1'b0};
            bh_in = {1'b0, r_ff - half_r};
         end
         default: begin
            bv_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (mask_ff != '0);
         mask_ff      <= take ? load_mask : rest;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         w_ff     <= load_w;
         h_ff     <= load_h;
         r_ff     <= load_r;
         y1_ff    <= y1_in;
         inset_ff <= load_inset;
         whole_ff <= whole_in;
      end
      if (mask_ff != '0) begin
         rsp_x_ff    <= x_in;
         rsp_y_ff    <= y_in;
         rsp_w_ff    <= bw_in;
         rsp_h_ff    <= bh_in;
         rsp_bv_ff   <= bv_in;
         rsp_last_ff <= (rest == '0);
      end
   end

   assign status.ready  = (rest == '0);
   assign status.active = (mask_ff != '0);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_band_x     = rsp_x_ff;
   assign rsp_band_y     = rsp_y_ff;
   assign rsp_band_w     = rsp_w_ff;
   assign rsp_band_h     = rsp_h_ff;
   assign rsp_band_valid = rsp_bv_ff;
   assign rsp_last_band  = rsp_last_ff;

   a_load_nonempty: assert property (@(posedge clock) disable iff (reset)
      take |=> mask_ff != '0)
      else $error("band plan loaded with no slot");

   a_pending_beat: assert property (@(posedge clock) disable iff (reset)
      mask_ff != '0 |=> rsp_valid_ff)
      else $error("pending band not sent");

   a_invalid_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bv_ff |-> rsp_last_ff)
      else $error("empty result not marked last");

endmodule

[hdl/rounded_rect_band_splitter_unit.sv]
`timescale 1ns / 1ps

// Splits each rectangle (start/busy) into up to five rounded-rectangle bands, one
// beat per cycle on rsp_valid, with rsp_last_band on the final beat. The receiver
// cannot stall: every beat must be taken in its cycle. A rectangle accepted on start
// passes the clamp, square and subtract stages, then one square-root cell per root
// bit, and a stall can hold it on the way; at the band emitter it is loaded into the
// slot mask and its beats leave through the output registers. The emitter sends one
// beat per cycle, and each rectangle yields 1 to 5 results (beats); busy is high
// while a finished rectangle waits at the end of the cell row for the emitter.
// Write csr_corner_radius only while no rectangle is in flight.
module rounded_rect_band_splitter_unit #(
   parameter int COORD_BITS = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [COORD_BITS-1:0] req_rect_width,
   input  logic [COORD_BITS-1:0] req_rect_height,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [COORD_BITS-2:0] csr_corner_radius,
   output logic                  rsp_valid,
   output logic [COORD_BITS-2:0] rsp_band_x,
   output logic [COORD_BITS-1:0] rsp_band_y,
   output logic [COORD_BITS-1:0] rsp_band_w,
   output logic [COORD_BITS-1:0] rsp_band_h,
   output logic                  rsp_band_valid,
   output logic                  rsp_last_band
);
   import rrbs_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int RB = COORD_BITS - 1;
   localparam int TAIL = RB - 1;

   logic            advance;
   logic            accept;
   emit_status_type status;

   logic [RB-1:0]   radius_ff;

   logic [CB-1:0]   min_in;
   logic [RB-1:0]   half_in;
   logic [RB-1:0]   r_in;

   logic            a_valid_ff;
   logic [CB-1:0]   a_w_ff;
   logic [CB-1:0]   a_h_ff;
   logic [RB-1:0]   a_r_ff;
   logic            a_empty_ff;

   logic [RB-1:0]   d_in;
   logic [2*RB-1:0] rsq_in;
   logic [2*RB-1:0] dsq_in;
   logic            steps2_in;

   logic            b_valid_ff;
   logic [CB-1:0]   b_w_ff;
   logic [CB-1:0]   b_h_ff;
   logic [RB-1:0]   b_r_ff;
   logic            b_empty_ff;
   logic            b_steps2_ff;
   logic [2*RB-1:0] b_rsq_ff;
   logic [2*RB-1:0] b_dsq_ff;

   logic            c_valid_ff;
   logic [CB-1:0]   c_w_ff;
   logic [CB-1:0]   c_h_ff;
   logic [RB-1:0]   c_r_ff;
   logic            c_empty_ff;
   logic            c_steps2_ff;
   logic [2*RB-1:0] c_rad_ff;

   logic [2*RB-1:0] rad_w  [0:RB];
   logic [RB+1:0]   rem_w  [0:RB];
   logic [RB-1:0]   root_w [0:RB];

   logic            side_valid_ff  [0:RB-1];
   logic [CB-1:0]   side_w_ff      [0:RB-1];
   logic [CB-1:0]   side_h_ff      [0:RB-1];
   logic [RB-1:0]   side_r_ff      [0:RB-1];
   logic            side_empty_ff  [0:RB-1];
   logic            side_steps2_ff [0:RB-1];

   logic            take;
   logic [RB-1:0]   tail_inset;

   assign advance   = !side_valid_ff[TAIL] || status.ready;
   assign busy      = !advance;
   assign accept    = start && advance;
   assign take      = side_valid_ff[TAIL] && status.ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         radius_ff <= csr_corner_radius;
      end
   end

   // clamp radius to half the smaller side
   always_comb begin
      min_in  = (req_rect_width < req_rect_height) ? req_rect_width : req_rect_height;
      half_in = min_in[CB-1:1];
      r_in    = (radius_ff > half_in) ? half_in : radius_ff;
   end

   always_comb begin
      d_in      = a_r_ff - {1'b0, a_r_ff[RB-1:1]};
      rsq_in    = {{RB{1'b0}}, a_r_ff} * {{RB{1'b0}}, a_r_ff};
      dsq_in    = {{RB{1'b0}}, d_in} * {{RB{1'b0}}, d_in};
      steps2_in = ({a_r_ff, 1'b0} >= a_h_ff) || ({a_r_ff, 1'b0} >= a_w_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         for (int i = 0; i < RB; i++) side_valid_ff[i] <= 1'b0;
      end else if (advance) begin
         a_valid_ff       <= accept;
         b_valid_ff       <= a_valid_ff;
         c_valid_ff       <= b_valid_ff;
         side_valid_ff[0] <= c_valid_ff;
         for (int i = 1; i < RB; i++) side_valid_ff[i] <= side_valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_w_ff      <= req_rect_width;
         a_h_ff      <= req_rect_height;
         a_r_ff      <= r_in;
         a_empty_ff  <= (req_rect_width == '0) || (req_rect_height == '0);
         b_w_ff      <= a_w_ff;
         b_h_ff      <= a_h_ff;
         b_r_ff      <= a_r_ff;
         b_empty_ff  <= a_empty_ff;
         b_steps2_ff <= steps2_in;
         b_rsq_ff    <= rsq_in;
         b_dsq_ff    <= dsq_in;
         c_w_ff      <= b_w_ff;
         c_h_ff      <= b_h_ff;
         c_r_ff      <= b_r_ff;
         c_empty_ff  <= b_empty_ff;
         c_steps2_ff <= b_steps2_ff;
         c_rad_ff    <= b_rsq_ff - b_dsq_ff;
         side_w_ff[0]      <= c_w_ff;
         side_h_ff[0]      <= c_h_ff;
         side_r_ff[0]      <= c_r_ff;
         side_empty_ff[0]  <= c_empty_ff;
         side_steps2_ff[0] <= c_steps2_ff;
         for (int i = 1; i < RB; i++) begin
            side_w_ff[i]      <= side_w_ff[i-1];
            side_h_ff[i]      <= side_h_ff[i-1];
            side_r_ff[i]      <= side_r_ff[i-1];
            side_empty_ff[i]  <= side_empty_ff[i-1];
            side_steps2_ff[i] <= side_steps2_ff[i-1];
         end
      end
   end

   assign rad_w[0]  = c_rad_ff;
   assign rem_w[0]  = '0;
   assign root_w[0] = '0;

   for (genvar j = 0; j < RB; j++) begin : g_cell
      rrbs_sqrt_cell #(
         .RB  (RB),
         .IDX (RB - 1 - j)
      ) u_cell (
         .clock     (clock),
         .advance   (advance),
         .prev_rad  (rad_w[j]),
         .prev_rem  (rem_w[j]),
         .prev_root (root_w[j]),
         .rad_out   (rad_w[j+1]),
         .rem_out   (rem_w[j+1]),
         .root_out  (root_w[j+1])
      );
   end

   assign tail_inset = side_r_ff[TAIL] - root_w[RB];

   rrbs_band_emitter #(
      .CB (CB)
   ) u_emitter (
      .clock          (clock),
      .reset          (reset),
      .take           (take),
      .load_w         (side_w_ff[TAIL]),
      .load_h         (side_h_ff[TAIL]),
      .load_r         (side_r_ff[TAIL]),
      .load_empty     (side_empty_ff[TAIL]),
      .load_steps2    (side_steps2_ff[TAIL]),
      .load_inset     (tail_inset),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_band_x     (rsp_band_x),
      .rsp_band_y     (rsp_band_y),
      .rsp_band_w     (rsp_band_w),
      .rsp_band_h     (rsp_band_h),
      .rsp_band_valid (rsp_band_valid),
      .rsp_last_band  (rsp_last_band)
   );

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> a_valid_ff)
      else $error("accepted rectangle lost at entry");

   a_tail_holds: assert property (@(posedge clock) disable iff (reset)
      busy |=> side_valid_ff[TAIL] && $stable(side_w_ff[TAIL]))
      else $error("stalled rectangle changed at end of cell row");

   a_busy_emitting: assert property (@(posedge clock) disable iff (reset)
      busy |-> status.active)
      else $error("busy with idle emitter");

endmodule

[test/rounded_rect_band_splitter_checker.sv]
`timescale 1ns / 1ps

module rounded_rect_band_splitter_checker #(
   parameter int COORD_BITS = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [COORD_BITS-1:0] req_rect_width,
   input  logic [COORD_BITS-1:0] req_rect_height,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [COORD_BITS-2:0] csr_corner_radius,
   input  logic                  rsp_valid,
   input  logic [COORD_BITS-2:0] rsp_band_x,
   input  logic [COORD_BITS-1:0] rsp_band_y,
   input  logic [COORD_BITS-1:0] rsp_band_w,
   input  logic [COORD_BITS-1:0] rsp_band_h,
   input  logic                  rsp_band_valid,
   input  logic                  rsp_last_band,
   output int                    error_count,
   output int                    bands_pending
);

   typedef struct packed {
      logic [COORD_BITS-2:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] w;
      logic [COORD_BITS-1:0] h;
      logic                  valid;
      logic                  last;
   } band_type;

   band_type              band_q[$];
   logic [COORD_BITS-2:0] radius_reg;

   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 16; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   function automatic band_type make_band(input longint unsigned x, y, w, h,
                                          input logic valid);
      band_type b;
      b.x     = x[COORD_BITS-2:0];
      b.y     = y[COORD_BITS-1:0];
      b.w     = w[COORD_BITS-1:0];
      b.h     = h[COORD_BITS-1:0];
      b.valid = valid;
      b.last  = 1'b0;
      return b;
   endfunction

   // queue up the bands one rectangle splits into
   function automatic void predict_bands(input longint unsigned w, h, r_req);
      band_type        bands[5];
      int              n;
      longint unsigned r, half, steps, y0, y1, d, inset;
      n = 0;
      r = r_req;
      if (w == 0 || h == 0) begin
         bands[0] = make_band('0, '0, '0, '0, 1'b0);
         n = 1;
      end else begin
         half = ((w < h) ? w : h) / 2;
         if (r > half) r = half;
         if (r == 0) begin
            bands[0] = make_band('0, '0, w, h, 1'b1);
            n = 1;
         end else begin
            steps = (2 * r >= h || 2 * r >= w) ? 2 : 1;
            if (h > 2 * r) begin
               bands[n] = make_band('0, r, w, h - 2 * r, 1'b1);
               n++;
            end
            for (longint unsigned i = 0; i < steps; i++) begin
               y0    = r * i / steps;
               y1    = r * (i + 1) / steps;
               d     = r - y0;
               inset = r - floor_root(r * r - d * d);
               if (y1 > y0 && w > 2 * inset) begin
                  bands[n]     = make_band(inset, y0, w - 2 * inset, y1 - y0, 1'b1);
                  bands[n + 1] = make_band(inset, h - y1, w - 2 * inset, y1 - y0, 1'b1);
                  n += 2;
               end
            end
            if (n == 0) begin
               bands[0] = make_band('0, '0, '0, '0, 1'b0);
               n = 1;
            end
         end
      end
      bands[n - 1].last = 1'b1;
      for (int k = 0; k < n; k++) band_q.push_back(bands[k]);
   endfunction

   task automatic check_field(input string name, input logic [COORD_BITS-1:0] want,
                              input logic [COORD_BITS-1:0] got);
      if (got !== want) begin
         $error("%s expected %0d got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      band_type want;
      if (reset) begin
         radius_reg = '0;
         band_q.delete();
      end else begin
         if (csr_valid && csr_ready) radius_reg = csr_corner_radius;
         if (rsp_valid) begin
            if (band_q.size() == 0) begin
               $error("band beat with nothing pending");
               error_count++;
            end else begin
               want = band_q.pop_front();
               check_field("band_x", COORD_BITS'(want.x), COORD_BITS'(rsp_band_x));
               check_field("band_y", want.y, rsp_band_y);
               check_field("band_w", want.w, rsp_band_w);
               check_field("band_h", want.h, rsp_band_h);
               check_field("band_valid", COORD_BITS'(want.valid),
                           COORD_BITS'(rsp_band_valid));
               check_field("last_band", COORD_BITS'(want.last),
                           COORD_BITS'(rsp_last_band));
            end
         end
         if (start && !busy) begin
            predict_bands(64'(req_rect_width), 64'(req_rect_height),
                          64'(radius_reg));
         end
      end
      bands_pending = band_q.size();
   end

endmodule

[test/rounded_rect_band_splitter_unit_tb.sv]
`timescale 1ns / 1ps

module rounded_rect_band_splitter_unit_tb;

   localparam int COORD_BITS = 15;
   localparam int MAX_COORD  = (1 << COORD_BITS) - 1;
   localparam int MAX_RADIUS = (1 << (COORD_BITS - 1)) - 1;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [COORD_BITS-1:0] req_rect_width;
   logic [COORD_BITS-1:0] req_rect_height;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [COORD_BITS-2:0] csr_corner_radius;
   logic                  rsp_valid;
   logic [COORD_BITS-2:0] rsp_band_x;
   logic [COORD_BITS-1:0] rsp_band_y;
   logic [COORD_BITS-1:0] rsp_band_w;
   logic [COORD_BITS-1:0] rsp_band_h;
   logic                  rsp_band_valid;
   logic                  rsp_last_band;
   int                    error_count;
   int                    bands_pending;
   int unsigned           radius_now;

   rounded_rect_band_splitter_unit #(
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_rect_width(req_rect_width),
      .req_rect_height(req_rect_height),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_corner_radius(csr_corner_radius),
      .rsp_valid(rsp_valid),
      .rsp_band_x(rsp_band_x),
      .rsp_band_y(rsp_band_y),
      .rsp_band_w(rsp_band_w),
      .rsp_band_h(rsp_band_h),
      .rsp_band_valid(rsp_band_valid),
      .rsp_last_band(rsp_last_band)
   );

   rounded_rect_band_splitter_checker #(
      .COORD_BITS(COORD_BITS)
   ) band_check (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_rect_width(req_rect_width),
      .req_rect_height(req_rect_height),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_corner_radius(csr_corner_radius),
      .rsp_valid(rsp_valid),
      .rsp_band_x(rsp_band_x),
      .rsp_band_y(rsp_band_y),
      .rsp_band_w(rsp_band_w),
      .rsp_band_h(rsp_band_h),
      .rsp_band_valid(rsp_band_valid),
      .rsp_last_band(rsp_last_band),
      .error_count(error_count),
      .bands_pending(bands_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("rounded_rect_band_splitter_unit_tb: errors");
      $finish;
   end

   function automatic int unsigned pick_gap();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // only called with the block idle
   task automatic write_radius(input int unsigned value);
      csr_valid         <= 1'b1;
      csr_corner_radius <= value[COORD_BITS-2:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid  <= 1'b0;
      radius_now = value;
   endtask

   task automatic send_rect(input int unsigned w, h);
      int unsigned gap;
      gap = pick_gap();
      start           <= 1'b1;
      req_rect_width  <= w[COORD_BITS-1:0];
      req_rect_height <= h[COORD_BITS-1:0];
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (bands_pending != 0) @(negedge clock);
   endtask

   initial begin
      int unsigned w, h, lim, mode, rad;
      reset             = 1'b1;
      start             = 1'b0;
      req_rect_width    = '0;
      req_rect_height   = '0;
      csr_valid         = 1'b0;
      csr_corner_radius = '0;
      radius_now        = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // radius clamped to half the smaller side
      write_radius(MAX_RADIUS);
      send_rect(0, 0);
      send_rect(0, MAX_COORD);
      send_rect(MAX_COORD, 0);
      send_rect(1, 1);
      send_rect(2, 2);
      send_rect(3, 3);
      send_rect(MAX_COORD, MAX_COORD);
      send_rect(MAX_COORD, 1);
      send_rect(1, MAX_COORD);
      send_rect(4, MAX_COORD);
      send_rect(MAX_COORD, 5);
      send_rect(100, 37);
      send_rect(16384, 21845);
      drain();
      write_radius(0);
      send_rect(MAX_COORD, MAX_COORD);
      send_rect(1, 1);
      send_rect(123, 45);
      drain();
      write_radius(1);
      send_rect(2, 2);
      send_rect(2, 3);
      send_rect(3, 2);
      send_rect(2, 100);
      drain();
      write_radius(5);
      send_rect(100, 100);
      send_rect(11, 100);
      send_rect(10, 100);
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: rad = 3;
            1: rad = MAX_RADIUS;
            2: rad = 2;
            3: rad = 7;
            4: rad = $urandom_range(1, 64);
            5: rad = 12345;
            6: rad = $urandom_range(0, MAX_RADIUS);
            7: rad = 40;
            8: rad = 1;
            default: rad = 0;
         endcase
         write_radius(rad);
         repeat (39) begin
            mode = $urandom_range(0, 99);
            if (mode < 8) begin
               w = $urandom_range(0, MAX_COORD);
               h = $urandom_range(0, MAX_COORD);
            end else if (mode < 14) begin
               w = (mode < 11) ? 0 : $urandom_range(0, MAX_COORD);
               h = (mode < 11) ? $urandom_range(0, MAX_COORD) : 0;
            end else if (mode < 20) begin
               w = MAX_COORD - $urandom_range(0, 255);
               h = (mode < 17) ? MAX_COORD - $urandom_range(0, 255) : $urandom_range(1, 8);
            end else begin
               lim = 2 * radius_now + 8;
               if (lim > MAX_COORD) lim = MAX_COORD;
               w = $urandom_range(1, lim);
               h = $urandom_range(1, lim);
            end
            send_rect(w, h);
         end
         drain();
      end

      repeat (40) @(negedge clock);
      if (error_count == 0) begin
         $display("rounded_rect_band_splitter_unit_tb: clean");
      end else begin
         $display("rounded_rect_band_splitter_unit_tb: errors");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/rrbs_pkg.sv
hdl/rrbs_sqrt_cell.sv
hdl/rrbs_band_emitter.sv
hdl/rounded_rect_band_splitter_unit.sv
test/rounded_rect_band_splitter_checker.sv
test/rounded_rect_band_splitter_unit_tb.sv
